>>> rtl/csq_pkg.sv
// csq_pkg: shared constants and types of the counting semaphore wait queue unit
// used by csq_ctrl, csq_datapath and counting_semaphore_wait_queue_unit
`default_nettype none

package csq_pkg;

    // default sizes
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    // fixed field widths
    localparam int CNT_W     = 16;
    localparam int PORT_ID_W = 8;
    localparam int WAIT_W    = 5;
    localparam int ERR_W     = 2;

    localparam logic [CNT_W-1:0] MAX_HOLDERS_RST = 16'd1;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL      = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd2;

    // request modes
    localparam logic MODE_ACQUIRE = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the incoming item
        logic execute;   // apply the latched item to the state
    } t_cmd;

endpackage

`default_nettype wire

>>> rtl/csq_ctrl.sv
// csq_ctrl: sequencing state machine of the semaphore unit
// depends on csq_pkg for the command struct
`default_nettype none

module csq_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output csq_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_EXEC;
                        r_in_ready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_state     <= S_RESP;
                    r_out_valid <= 1'b1;
                end
                S_RESP: begin
                    if (i_out_ready) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_ready  <= 1'b1;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_in_ready  <= 1'b1;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_ready    = r_in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = r_in_ready & i_in_valid;
    assign o_cmd.execute = (r_state == S_EXEC);

endmodule

`default_nettype wire

>>> rtl/csq_datapath.sv
// csq_datapath: holder counter, fifo wait queue memory and result registers
// depends on csq_pkg; driven by csq_ctrl commands
`default_nettype none

module csq_datapath #(
    parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = csq_pkg::ID_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire csq_pkg::t_cmd                    i_cmd,
    input  wire logic                             i_cfg_we,
    input  wire logic [csq_pkg::CNT_W-1:0]        i_cfg_wdata,
    input  wire logic                             i_mode,
    input  wire logic [csq_pkg::PORT_ID_W-1:0]    i_requester_id,
    output logic                                  o_granted,
    output logic                                  o_queued,
    output logic                                  o_woken_valid,
    output logic [csq_pkg::PORT_ID_W-1:0]         o_woken_id,
    output logic [csq_pkg::ERR_W-1:0]             o_error_code,
    output logic                                  o_can_acquire,
    output logic [csq_pkg::CNT_W-1:0]             o_held_count,
    output logic [csq_pkg::WAIT_W-1:0]            o_waiters
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PID_W  = csq_pkg::PORT_ID_W;
    localparam int WAIT_W = csq_pkg::WAIT_W;
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

    logic [ID_BITS-1:0] r_mem [QUEUE_DEPTH];

    logic [csq_pkg::CNT_W-1:0] r_max;
    logic [csq_pkg::CNT_W-1:0] r_count;
    logic [PTR_W-1:0]          r_head;
    logic [PTR_W-1:0]          r_tail;
    logic [FILL_W-1:0]         r_fill;

    logic                      r_mode;
    logic [ID_BITS-1:0]        r_id;
    logic [ID_BITS-1:0]        r_rdata;

    logic                      r_granted;
    logic                      r_queued;
    logic                      r_woken;
    logic [csq_pkg::ERR_W-1:0] r_err;

    logic [ID_BITS-1:0]        w_id_in;
    logic [PID_W-1:0]          w_id_out;
    logic                      w_below;
    logic                      w_has_room;
    logic                      w_has_waiter;
    logic                      w_do_grant;
    logic                      w_do_push;
    logic                      w_do_pop;
    logic                      w_do_dec;

    // width adaption between port ids and stored ids
    if (ID_BITS >= PID_W) begin : g_id_wide
        assign w_id_in  = ID_BITS'(i_requester_id);
        assign w_id_out = r_rdata[PID_W-1:0];
    end else begin : g_id_narrow
        assign w_id_in  = i_requester_id[ID_BITS-1:0];
        assign w_id_out = PID_W'(r_rdata);
    end

    if (FILL_W >= WAIT_W) begin : g_wait_wide
        assign o_waiters = r_fill[WAIT_W-1:0];
    end else begin : g_wait_narrow
        assign o_waiters = WAIT_W'(r_fill);
    end

    assign w_below      = (r_count < r_max);
    assign w_has_room   = (r_fill < FILL_MAX);
    assign w_has_waiter = (r_fill != '0);

    always_comb begin
        w_do_grant = 1'b0;
        w_do_push  = 1'b0;
        w_do_pop   = 1'b0;
        w_do_dec   = 1'b0;
        if (i_cmd.execute) begin
            if (r_mode == csq_pkg::MODE_ACQUIRE) begin
                w_do_grant = w_below;
                w_do_push  = !w_below && w_has_room;
            end else begin
                w_do_pop   = w_has_waiter;
                w_do_dec   = !w_has_waiter && (r_count != '0);
            end
        end
    end

    // wait queue memory
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_tail] <= r_id;
        end
        if (i_cmd.execute) begin
            r_rdata <= r_mem[r_head];
        end
    end

    // semaphore state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= csq_pkg::MAX_HOLDERS_RST;
            r_count <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (w_do_grant) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_dec) begin
                r_count <= r_count - 1'b1;
            end
            if (w_do_push) begin
                r_tail <= (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
                r_fill <= r_fill + 1'b1;
            end else if (w_do_pop) begin
                r_head <= (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // latched item and result flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_id   <= w_id_in;
        end
        if (i_cmd.execute) begin
            r_granted <= w_do_grant;
            r_queued  <= w_do_push;
            r_woken   <= w_do_pop;
            if (r_mode == csq_pkg::MODE_ACQUIRE) begin
                r_err <= (!w_below && !w_has_room) ? csq_pkg::ERR_FULL : csq_pkg::ERR_OK;
            end else begin
                r_err <= (!w_has_waiter && (r_count == '0)) ? csq_pkg::ERR_UNDERFLOW
                                                            : csq_pkg::ERR_OK;
            end
        end
    end

    assign o_granted     = r_granted;
    assign o_queued      = r_queued;
    assign o_woken_valid = r_woken;
    assign o_woken_id    = r_woken ? w_id_out : '0;
    assign o_error_code  = r_err;
    assign o_can_acquire = w_below;
    assign o_held_count  = r_count;

endmodule

`default_nettype wire

>>> rtl/counting_semaphore_wait_queue_unit.sv
// counting_semaphore_wait_queue_unit: top level of the hardware counting semaphore
// depends on csq_pkg, csq_ctrl and csq_datapath
//
// usage
// - input channel i_in_valid / o_in_ready carries one request item: i_mode
//   (0 acquire, 1 release) and i_requester_id
// - output channel o_out_valid / i_out_ready returns one result item per request
// - max_holders is written through i_cfg_we / i_cfg_wdata while the unit is idle
// sequencing
// - one request at a time: the sequencer latches the item on acceptance,
//   executes it against counter and queue memory, registers the result and
//   raises o_out_valid, and takes no new item until the result is delivered
// reset
// - synchronous active low: count, queue pointers and fill cleared, max_holders
//   back to 1; the queue memory itself is not cleared
// stall
// - while the receiver holds i_out_ready low the result stays registered and
//   o_in_ready stays low, so no request is taken until it is delivered
`default_nettype none

module counting_semaphore_wait_queue_unit #(
    parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = csq_pkg::ID_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [csq_pkg::CNT_W-1:0]        i_cfg_wdata,
    // request channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_mode,
    input  wire logic [csq_pkg::PORT_ID_W-1:0]    i_requester_id,
    // result channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_granted,
    output logic                                  o_queued,
    output logic                                  o_woken_valid,
    output logic [csq_pkg::PORT_ID_W-1:0]         o_woken_id,
    output logic [csq_pkg::ERR_W-1:0]             o_error_code,
    output logic                                  o_can_acquire,
    output logic [csq_pkg::CNT_W-1:0]             o_held_count,
    output logic [csq_pkg::WAIT_W-1:0]            o_waiters
);

    // command bundle from the sequencer to the datapath
    csq_pkg::t_cmd w_cmd;

    // sequencer: idle, execute, deliver
    csq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // counter, wait queue and result registers
    csq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_mode         (i_mode),
        .i_requester_id (i_requester_id),
        .o_granted      (o_granted),
        .o_queued       (o_queued),
        .o_woken_valid  (o_woken_valid),
        .o_woken_id     (o_woken_id),
        .o_error_code   (o_error_code),
        .o_can_acquire  (o_can_acquire),
        .o_held_count   (o_held_count),
        .o_waiters      (o_waiters)
    );

endmodule

`default_nettype wire
